### rtl/gww_pkg.sv
// Shared types, register codes and constants of the greedy word wrap unit.
package gww_pkg;

  // Default width of byte offsets and line lengths inside the unit.
  localparam int OFFSET_BITS_DEF = 16;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SPACING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LINES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINES     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY    = 3'd6;

  // Configuration values after reset.
  localparam logic [7:0]  GLYPH_WIDTH_RST   = 8'd8;
  localparam logic [7:0]  GLYPH_SPACING_RST = 8'd1;
  localparam logic [7:0]  SCALE_RST         = 8'd1;
  localparam logic [14:0] MAX_WIDTH_RST     = 15'd128;
  localparam logic [15:0] SKIP_LINES_RST    = 16'd0;
  localparam logic [7:0]  MAX_LINES_RST     = 8'd255;
  localparam logic        COUNT_ONLY_RST    = 1'b0;

  // Result kinds.
  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Widest reported line width, and the glyph counter ceiling.
  localparam logic [14:0] WIDTH_MAX = 15'h7FFF;
  localparam logic [15:0] GLYPH_SAT = 16'hFFFF;

  // Raw line widths (sums of advances) stay below 2^19 even with config
  // changes between bytes.
  localparam int RAW_W = 19;

  // Most result beats one input byte can cause.
  localparam int MAX_RES = 3;

  // One input beat.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic        result_kind;
    logic [15:0] line_start;
    logic [15:0] line_length;
    logic [14:0] width_px;
    logic [15:0] line_total;
    logic        last_result;
  } out_beat_t;

  // Line counters of the text in progress.
  typedef struct packed {
    logic [15:0] seen;
    logic [7:0]  written;
    logic        stopped;
  } tally_t;

  // Counters after one finished line, and whether that line is output.
  typedef struct packed {
    tally_t t;
    logic   put;
  } emit_out_t;

endpackage

### rtl/greedy_word_wrap_unit.sv
// Greedy monospace word wrapper: UTF-8 bytes in, wrapped line records out.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_stall  | in_data   (text byte, final)
//   out     | output    | out_valid / out_stall| out_data  (line or summary)
//   cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_stall is low; all of its work is done in
// the cycle it is accepted and its result beats (up to three) land in a
// four-entry queue. The output port drains one beat per cycle while out_stall
// is low; in_stall is high while the queue holds more than one beat. Reset is
// synchronous and active low; it restores the register defaults and clears
// the text state at once, with no clearing pass.
// Glyph advance products are formed on the configuration write itself.
module greedy_word_wrap_unit #(
  parameter int OFFSET_BITS = gww_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gww_pkg::in_beat_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gww_pkg::out_beat_t               out_data,
  input  logic                             cfg_we,
  input  logic [gww_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gww_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gww_pkg::*;

  typedef logic [OFFSET_BITS-1:0] off_t;

  // A finished line: where it starts, how many bytes, how wide.
  typedef struct packed {
    off_t        start;
    off_t        len;
    logic [14:0] width;
  } line_t;

  // The blank line held back until real content follows.
  typedef struct packed {
    logic  v;
    line_t ln;
  } held_t;

  localparam off_t OFF_ONE   = off_t'(1);
  localparam int   QDEPTH    = MAX_RES + 1;
  localparam int   QIDX_W    = $clog2(QDEPTH);
  localparam int   QCNT_W    = $clog2(QDEPTH + 1);
  localparam int   RES_SLOTS = MAX_RES + 1;
  localparam logic [15:0] GPX_RST = 16'(GLYPH_WIDTH_RST * SCALE_RST);
  localparam logic [15:0] SP_RST  = 16'(GLYPH_SPACING_RST * SCALE_RST);
  localparam logic [16:0] ADV_RST = 17'(GPX_RST) + 17'(SP_RST);

  // Configuration and derived advance values.
  logic [7:0]  gw_r, gw_nxt, gs_r, gs_nxt, scale_r, scale_nxt, maxl_r, maxl_nxt;
  logic [14:0] maxw_r, maxw_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic        cnt_only_r, cnt_only_nxt;
  logic [15:0] gpx_r, gpx_nxt, sp_r, sp_nxt;
  logic [16:0] adv_r, adv_nxt;

  // Text state.
  off_t             bytepos_r, bytepos_nxt, cls_r, cls_nxt, cand_off_r, cand_off_nxt;
  logic [15:0]      glyphs_r, glyphs_nxt;
  logic [RAW_W-1:0] raw_r, raw_nxt, wafter_r, wafter_nxt;
  logic             cand_v_r, cand_v_nxt, content_r, content_nxt;
  logic [14:0]      wbefore_r, wbefore_nxt;
  logic [16:0]      cand_g_r, cand_g_nxt;
  held_t            held_r, held_nxt;
  tally_t           tally_r, tally_nxt;

  // Result queue.
  out_beat_t        q_r [QDEPTH];
  out_beat_t        q_nxt [QDEPTH];
  logic [QCNT_W-1:0] qcnt_r, qcnt_nxt;

  // Per-byte datapath signals.
  logic             in_acc, fin_acc, active, is_space, is_cont, is_nl, over, pop;
  logic [RAW_W-1:0] newraw, sp_x, rr;
  logic [15:0]      rg;
  logic [14:0]      cur_w;
  logic             a_req, b_req, c_req, s_v;
  line_t            a_ln, b_ln, c_ln;
  emit_out_t        ea, eb, ec;
  out_beat_t        res_beat [RES_SLOTS];
  logic [RES_SLOTS-1:0] res_vld;

  // Visible width of a line: advances less one trailing gap, saturated.
  function automatic logic [14:0] shown_w(logic [15:0] glyphs, logic [RAW_W-1:0] raw,
                                          logic [RAW_W-1:0] spx);
    logic [RAW_W-1:0] d;
    d = raw - spx;
    if (glyphs == '0 || raw < spx) return '0;
    if (d > RAW_W'(WIDTH_MAX)) return WIDTH_MAX;
    return d[14:0];
  endfunction

  // Glyph counter with a ceiling.
  function automatic logic [15:0] sat_inc(logic [15:0] g);
    return (g == GLYPH_SAT) ? g : g + 16'd1;
  endfunction

  // Offset as a 16-bit result field.
  function automatic logic [15:0] off16(off_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  // Counts one finished line and decides whether it is output.
  function automatic emit_out_t tally_emit(tally_t t, logic req, logic co,
                                           logic [15:0] skip, logic [7:0] maxl);
    emit_out_t e;
    e.t   = t;
    e.put = 1'b0;
    if (req && !t.stopped) begin
      if (co) begin
        e.t.seen = t.seen + 16'd1;
      end else begin
        if (t.seen >= skip && t.written < maxl) begin
          e.put       = 1'b1;
          e.t.written = t.written + 8'd1;
        end
        e.t.seen    = t.seen + 16'd1;
        e.t.stopped = (e.t.written >= maxl);
      end
    end
    return e;
  endfunction

  // Line result beat.
  function automatic out_beat_t line_beat(line_t ln, logic [7:0] written);
    out_beat_t b;
    b.result_kind = KIND_LINE;
    b.line_start  = off16(ln.start);
    b.line_length = off16(ln.len);
    b.width_px    = ln.width;
    b.line_total  = 16'(written);
    b.last_result = 1'b0;
    return b;
  endfunction

  // Handshakes.
  assign in_stall  = (qcnt_r > QCNT_W'(QDEPTH - MAX_RES));
  assign in_acc    = in_valid && !in_stall;
  assign fin_acc   = in_acc && in_data.final_byte;
  assign out_valid = (qcnt_r != '0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;

  // Configuration writes; the advance products follow the new values.
  always_comb begin
    gw_nxt       = gw_r;
    gs_nxt       = gs_r;
    scale_nxt    = scale_r;
    maxw_nxt     = maxw_r;
    skip_nxt     = skip_r;
    maxl_nxt     = maxl_r;
    cnt_only_nxt = cnt_only_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GLYPH_WIDTH:   gw_nxt       = cfg_wdata[7:0];
        CFG_GLYPH_SPACING: gs_nxt       = cfg_wdata[7:0];
        CFG_SCALE:         scale_nxt    = cfg_wdata[7:0];
        CFG_MAX_WIDTH:     maxw_nxt     = cfg_wdata[14:0];
        CFG_SKIP_LINES:    skip_nxt     = cfg_wdata;
        CFG_MAX_LINES:     maxl_nxt     = cfg_wdata[7:0];
        CFG_COUNT_ONLY:    cnt_only_nxt = cfg_wdata[0];
        default:           ;
      endcase
    end
    gpx_nxt = gw_nxt * scale_nxt;
    sp_nxt  = gs_nxt * scale_nxt;
    adv_nxt = 17'(gpx_nxt) + 17'(sp_nxt);
  end

  // Byte classification and width arithmetic of the current line.
  assign is_space = (in_data.text_byte == CHAR_SPACE);
  assign is_nl    = (in_data.text_byte == CHAR_NL);
  assign is_cont  = (in_data.text_byte[7:6] == 2'b10);
  assign active   = !tally_r.stopped && (gpx_r <= 16'(maxw_r));
  assign sp_x     = RAW_W'(sp_r);
  assign newraw   = raw_r + RAW_W'(adv_r);
  assign over     = (glyphs_r != '0) && ((newraw < sp_x) || (newraw - sp_x > RAW_W'(maxw_r)));
  assign rg       = (17'(glyphs_r) >= cand_g_r) ? 16'(17'(glyphs_r) - cand_g_r) : '0;
  assign rr       = (raw_r >= wafter_r) ? raw_r - wafter_r : '0;
  assign cur_w    = shown_w(glyphs_r, raw_r, sp_x);

  // Line state update for one accepted byte.
  always_comb begin
    bytepos_nxt  = bytepos_r;
    cls_nxt      = cls_r;
    glyphs_nxt   = glyphs_r;
    raw_nxt      = raw_r;
    cand_v_nxt   = cand_v_r;
    cand_off_nxt = cand_off_r;
    wbefore_nxt  = wbefore_r;
    wafter_nxt   = wafter_r;
    cand_g_nxt   = cand_g_r;
    content_nxt  = content_r;
    held_nxt     = held_r;
    a_req        = 1'b0;
    b_req        = 1'b0;
    a_ln         = held_r.ln;
    b_ln.start   = cls_r;
    b_ln.len     = bytepos_r - cls_r;
    b_ln.width   = cur_w;
    if (in_acc) begin
      if (active) begin
        // Anything but a space releases a held blank line.
        if (!is_space) begin
          if (held_r.v) begin
            a_req      = 1'b1;
            held_nxt.v = 1'b0;
          end
          content_nxt = 1'b1;
        end
        priority if (is_cont) begin
          // Continuation bytes belong to the glyph before them.
        end else if (is_nl) begin
          b_req       = 1'b1;
          cls_nxt     = bytepos_r + OFF_ONE;
          glyphs_nxt  = '0;
          raw_nxt     = '0;
          cand_v_nxt  = 1'b0;
          content_nxt = 1'b0;
        end else if (!over) begin
          // The glyph fits; a space after a glyph becomes the break point.
          if (is_space && glyphs_r != '0) begin
            cand_v_nxt   = 1'b1;
            cand_off_nxt = bytepos_r;
            wbefore_nxt  = cur_w;
            wafter_nxt   = newraw;
            cand_g_nxt   = 17'(glyphs_r) + 17'd1;
          end
          raw_nxt    = newraw;
          glyphs_nxt = sat_inc(glyphs_r);
        end else if (is_space) begin
          // Overflowing space: break here and drop it.
          if (content_r) begin
            b_req = 1'b1;
          end else begin
            if (held_r.v) begin
              b_req = 1'b1;
              b_ln  = held_r.ln;
            end
            held_nxt.v        = 1'b1;
            held_nxt.ln.start = cls_r;
            held_nxt.ln.len   = bytepos_r - cls_r;
            held_nxt.ln.width = cur_w;
          end
          cls_nxt     = bytepos_r + OFF_ONE;
          glyphs_nxt  = '0;
          raw_nxt     = '0;
          cand_v_nxt  = 1'b0;
          content_nxt = 1'b0;
        end else if (cand_v_r) begin
          // Break at the last space; the word after it moves down.
          b_req       = 1'b1;
          b_ln.len    = cand_off_r - cls_r;
          b_ln.width  = wbefore_r;
          cls_nxt     = cand_off_r + OFF_ONE;
          cand_v_nxt  = 1'b0;
          content_nxt = 1'b1;
          raw_nxt     = rr + RAW_W'(adv_r);
          glyphs_nxt  = sat_inc(rg);
        end else begin
          // Hard break just before this glyph.
          b_req       = 1'b1;
          cls_nxt     = bytepos_r;
          glyphs_nxt  = 16'd1;
          raw_nxt     = RAW_W'(adv_r);
          cand_v_nxt  = 1'b0;
          content_nxt = 1'b1;
        end
      end
      bytepos_nxt = bytepos_r + OFF_ONE;
    end
  end

  // Line counting, the closing line and the summary, in output order.
  always_comb begin
    ea         = tally_emit(tally_r, a_req, cnt_only_r, skip_r, maxl_r);
    eb         = tally_emit(ea.t, b_req, cnt_only_r, skip_r, maxl_r);
    c_req      = fin_acc && !eb.t.stopped && content_nxt;
    c_ln.start = cls_nxt;
    c_ln.len   = bytepos_nxt - cls_nxt;
    c_ln.width = shown_w(glyphs_nxt, raw_nxt, sp_x);
    ec         = tally_emit(eb.t, c_req, cnt_only_r, skip_r, maxl_r);
    tally_nxt  = in_acc ? ec.t : tally_r;

    res_vld[0] = in_acc && ea.put;
    res_vld[1] = in_acc && eb.put;
    res_vld[2] = ec.put;
    s_v        = fin_acc && (cnt_only_r || !(ea.put || eb.put || ec.put));
    res_vld[3] = s_v;

    res_beat[0] = line_beat(a_ln, ea.t.written);
    res_beat[1] = line_beat(b_ln, eb.t.written);
    res_beat[2] = line_beat(c_ln, ec.t.written);
    res_beat[0].last_result = fin_acc && !s_v && !res_vld[1] && !res_vld[2];
    res_beat[1].last_result = fin_acc && !s_v && !res_vld[2];
    res_beat[2].last_result = fin_acc && !s_v;

    res_beat[3].result_kind = KIND_SUMMARY;
    res_beat[3].line_start  = '0;
    res_beat[3].line_length = '0;
    res_beat[3].width_px    = '0;
    res_beat[3].line_total  = cnt_only_r ? ec.t.seen : 16'(ec.t.written);
    res_beat[3].last_result = 1'b1;
  end

  // Result queue: shift out on a taken beat, append this byte's beats.
  always_comb begin
    logic [QCNT_W-1:0] wr;
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[QDEPTH-1] = q_r[QDEPTH-1];
    wr = qcnt_r - QCNT_W'(pop);
    for (int k = 0; k < RES_SLOTS; k++) begin
      if (res_vld[k]) begin
        q_nxt[wr[QIDX_W-1:0]] = res_beat[k];
        wr = wr + QCNT_W'(1);
      end
    end
    qcnt_nxt = wr;
  end

  // Control state and queue count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r       <= GLYPH_WIDTH_RST;
      gs_r       <= GLYPH_SPACING_RST;
      scale_r    <= SCALE_RST;
      maxw_r     <= MAX_WIDTH_RST;
      skip_r     <= SKIP_LINES_RST;
      maxl_r     <= MAX_LINES_RST;
      cnt_only_r <= COUNT_ONLY_RST;
      gpx_r      <= GPX_RST;
      sp_r       <= SP_RST;
      adv_r      <= ADV_RST;
      qcnt_r     <= '0;
    end else begin
      gw_r       <= gw_nxt;
      gs_r       <= gs_nxt;
      scale_r    <= scale_nxt;
      maxw_r     <= maxw_nxt;
      skip_r     <= skip_nxt;
      maxl_r     <= maxl_nxt;
      cnt_only_r <= cnt_only_nxt;
      gpx_r      <= gpx_nxt;
      sp_r       <= sp_nxt;
      adv_r      <= adv_nxt;
      qcnt_r     <= qcnt_nxt;
    end
  end

  // Text state is cleared by reset and after every final byte.
  always_ff @(posedge clk) begin
    if (!rst_n || fin_acc) begin
      bytepos_r  <= '0;
      cls_r      <= '0;
      glyphs_r   <= '0;
      raw_r      <= '0;
      cand_v_r   <= 1'b0;
      cand_off_r <= '0;
      wbefore_r  <= '0;
      wafter_r   <= '0;
      cand_g_r   <= '0;
      content_r  <= 1'b0;
      held_r     <= '0;
      tally_r    <= '0;
    end else begin
      bytepos_r  <= bytepos_nxt;
      cls_r      <= cls_nxt;
      glyphs_r   <= glyphs_nxt;
      raw_r      <= raw_nxt;
      cand_v_r   <= cand_v_nxt;
      cand_off_r <= cand_off_nxt;
      wbefore_r  <= wbefore_nxt;
      wafter_r   <= wafter_nxt;
      cand_g_r   <= cand_g_nxt;
      content_r  <= content_nxt;
      held_r     <= held_nxt;
      tally_r    <= tally_nxt;
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // The queue never holds more beats than it has entries.
  assert property (@(posedge clk) disable iff (!rst_n) qcnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // A final byte always leaves at least one beat waiting.
  assert property (@(posedge clk) disable iff (!rst_n) fin_acc |=> qcnt_r != '0)
    else $error("final byte produced no result");

  // After a final byte the text state starts over.
  assert property (@(posedge clk) disable iff (!rst_n)
    fin_acc |=> (bytepos_r == '0 && !held_r.v && tally_r == '0 && !content_r))
    else $error("text state not cleared after final byte");

  // Once the line cap is reached no further line is output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && tally_r.stopped |-> !(res_vld[0] || res_vld[1] || res_vld[2]))
    else $error("line output after stop");

endmodule

### tb/greedy_word_wrap_unit_tb.sv
// Self-checking testbench for the greedy word wrap unit: UTF-8 texts in, line and summary beats checked.
module greedy_word_wrap_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gww_pkg::*;

  localparam longint unsigned OFS_MASK = 64'hFFFF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef logic [7:0] text_q_t [$];

  typedef struct {
    int unsigned gw;
    int unsigned gs;
    int unsigned sc;
    int unsigned maxw;
    int unsigned skip;
    int unsigned maxl;
    int unsigned co;
  } setting_t;

  // Tracks the wrapper state and queues the result beats each byte should produce.
  class wrap_tracker;
    int unsigned glyph_w, glyph_sp, scl, max_w, skip_n, max_n;
    bit tally_only;
    longint unsigned pos, line_start, cand_off, held_start, held_len;
    int unsigned glyphs, raw_w, cand_before, cand_after, cand_glyphs, held_w;
    bit cand_ok, has_content, held_ok, halted;
    int unsigned seen_n, written_n;
    out_beat_t step_beats[$];
    out_beat_t expected_lines[$];
    int unsigned errors;

    function new();
      glyph_w = GLYPH_WIDTH_RST;
      glyph_sp = GLYPH_SPACING_RST;
      scl = SCALE_RST;
      max_w = MAX_WIDTH_RST;
      skip_n = SKIP_LINES_RST;
      max_n = MAX_LINES_RST;
      tally_only = COUNT_ONLY_RST;
      errors = 0;
      clear_text();
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GLYPH_WIDTH: glyph_w = data[7:0];
        CFG_GLYPH_SPACING: glyph_sp = data[7:0];
        CFG_SCALE: scl = data[7:0];
        CFG_MAX_WIDTH: max_w = data[14:0];
        CFG_SKIP_LINES: skip_n = data;
        CFG_MAX_LINES: max_n = data[7:0];
        CFG_COUNT_ONLY: tally_only = data[0];
        default: ;
      endcase
    endfunction

    // Visible width: advances minus one trailing gap, saturated.
    function int unsigned shown(int unsigned g, int unsigned raw, int unsigned sp);
      int unsigned w;
      if (g == 0 || raw < sp) return 0;
      w = raw - sp;
      return (w > 32767) ? 32767 : w;
    endfunction

    function void put(logic kind, longint unsigned start, longint unsigned len,
                      int unsigned width, int unsigned total);
      out_beat_t b;
      if (step_beats.size() >= MAX_RES) return;
      b.result_kind = kind;
      b.line_start = start[15:0];
      b.line_length = len[15:0];
      b.width_px = width[14:0];
      b.line_total = total[15:0];
      b.last_result = 1'b0;
      step_beats.push_back(b);
    endfunction

    // A finished line passes through skip and cap before it becomes a beat.
    function void emit_line(longint unsigned start, longint unsigned stop_ofs,
                            int unsigned width);
      if (halted) return;
      if (tally_only) begin
        seen_n = (seen_n + 1) & 32'hFFFF;
        return;
      end
      if (seen_n >= skip_n && written_n < max_n) begin
        written_n++;
        put(KIND_LINE, start, (stop_ofs - start) & OFS_MASK, width, written_n);
      end
      seen_n = (seen_n + 1) & 32'hFFFF;
      if (written_n >= max_n) halted = 1'b1;
    endfunction

    function void new_line(longint unsigned start);
      line_start = start & OFS_MASK;
      glyphs = 0;
      raw_w = 0;
      cand_ok = 1'b0;
      has_content = 1'b0;
    endfunction

    function void add_glyph(logic [7:0] c, int unsigned nraw, int unsigned sp,
                            longint unsigned p);
      // A space after some glyph becomes the latest soft break point.
      if (c == CHAR_SPACE && glyphs > 0) begin
        cand_ok = 1'b1;
        cand_off = p;
        cand_before = shown(glyphs, raw_w, sp);
        cand_after = nraw;
        cand_glyphs = glyphs + 1;
      end
      raw_w = nraw;
      if (glyphs < 32'hFFFF) glyphs++;
    endfunction

    function void wrap_byte(logic [7:0] c, int unsigned adv, int unsigned sp);
      longint unsigned p;
      bit fresh;
      bit over;
      int unsigned nraw, w, rg, rr;
      p = pos;
      fresh = 1'b0;
      // Any non-space releases a held blank line and marks the line as real.
      if (c != CHAR_SPACE) begin
        if (held_ok) begin
          held_ok = 1'b0;
          emit_line(held_start, held_start + held_len, held_w);
        end
        has_content = 1'b1;
      end
      if (c[7:6] == 2'b10) return;
      if (c == CHAR_NL) begin
        emit_line(line_start, p, shown(glyphs, raw_w, sp));
        new_line(p + 1);
        return;
      end
      forever begin
        nraw = raw_w + adv;
        over = !fresh && glyphs > 0 && (nraw - sp) > max_w;
        if (!over) begin
          add_glyph(c, nraw, sp, p);
          return;
        end
        // An overflowing space ends the line and is dropped.
        if (c == CHAR_SPACE) begin
          w = shown(glyphs, raw_w, sp);
          if (has_content) begin
            emit_line(line_start, p, w);
          end else begin
            if (held_ok) emit_line(held_start, held_start + held_len, held_w);
            held_ok = 1'b1;
            held_start = line_start;
            held_len = (p - line_start) & OFS_MASK;
            held_w = w;
          end
          new_line(p + 1);
          return;
        end
        // Soft break at the last space, carrying the tail to the new line.
        if (cand_ok) begin
          rg = (glyphs >= cand_glyphs) ? glyphs - cand_glyphs : 0;
          rr = (raw_w >= cand_after) ? raw_w - cand_after : 0;
          emit_line(line_start, cand_off, cand_before);
          new_line(cand_off + 1);
          glyphs = rg;
          raw_w = rr;
        end else begin
          emit_line(line_start, p, shown(glyphs, raw_w, sp));
          new_line(p);
        end
        has_content = 1'b1;
        fresh = 1'b1;
      end
    endfunction

    function void clear_text();
      pos = 0;
      new_line(0);
      cand_off = 0;
      cand_before = 0;
      cand_after = 0;
      cand_glyphs = 0;
      held_ok = 1'b0;
      held_start = 0;
      held_len = 0;
      held_w = 0;
      seen_n = 0;
      written_n = 0;
      halted = 1'b0;
    endfunction

    // Called for every accepted input beat.
    function void note_byte(in_beat_t b);
      int unsigned gpx, sp, adv;
      gpx = glyph_w * scl;
      sp = glyph_sp * scl;
      adv = gpx + sp;
      step_beats.delete();
      if (!halted && gpx <= max_w) wrap_byte(b.text_byte, adv, sp);
      pos = (pos + 1) & OFS_MASK;
      if (b.final_byte) begin
        held_ok = 1'b0;
        if (!halted && has_content) emit_line(line_start, pos, shown(glyphs, raw_w, sp));
        if (tally_only) begin
          put(KIND_SUMMARY, 0, 0, 0, seen_n);
        end else if (step_beats.size() == 0) begin
          put(KIND_SUMMARY, 0, 0, 0, written_n);
        end
        step_beats[step_beats.size() - 1].last_result = 1'b1;
        clear_text();
      end
      foreach (step_beats[i]) expected_lines.push_back(step_beats[i]);
    endfunction

    function void flag(string what, out_beat_t want, out_beat_t got);
      errors++;
      if (errors <= 10)
        $display({"%s: expected kind=%0d start=%0d len=%0d width=%0d total=%0d last=%0d,",
                  " got kind=%0d start=%0d len=%0d width=%0d total=%0d last=%0d"},
                 what, want.result_kind, want.line_start, want.line_length,
                 want.width_px, want.line_total, want.last_result,
                 got.result_kind, got.line_start, got.line_length,
                 got.width_px, got.line_total, got.last_result);
    endfunction

    // Called for every accepted result beat.
    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (expected_lines.size() == 0) begin
        flag("unexpected beat", '0, got);
        return;
      end
      want = expected_lines.pop_front();
      if (got.result_kind !== want.result_kind || got.line_start !== want.line_start ||
          got.line_length !== want.line_length || got.width_px !== want.width_px ||
          got.line_total !== want.line_total || got.last_result !== want.last_result)
        flag("beat mismatch", want, got);
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_beat_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_stall;
  logic out_valid;
  out_beat_t out_data;
  bit calm = 1'b0;
  int unsigned cycles = 0;
  wrap_tracker tracker = new();

  greedy_word_wrap_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Random back-pressure on the result side.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 16);
    end
  end

  // Observe register writes, accepted bytes and accepted result beats.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) tracker.note_byte(in_data);
      if (out_valid && !out_stall) tracker.check_beat(out_data);
    end
  end

  task automatic send_byte(logic [7:0] c, logic fin);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{text_byte: c, final_byte: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(text_q_t t);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1);
  endtask

  task automatic send_str(string s);
    text_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_text(t);
  endtask

  // Hold the sender until every expected beat has come out, then let the unit settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic load_setting(setting_t s);
    drain();
    write_reg(CFG_GLYPH_WIDTH, s.gw);
    write_reg(CFG_GLYPH_SPACING, s.gs);
    write_reg(CFG_SCALE, s.sc);
    write_reg(CFG_MAX_WIDTH, s.maxw);
    write_reg(CFG_SKIP_LINES, s.skip);
    write_reg(CFG_MAX_LINES, s.maxl);
    write_reg(CFG_COUNT_ONLY, s.co);
    cfg_we <= 1'b0;
  endtask

  // Mostly words and spaces, with newlines, UTF-8 sequences, stray continuations and noise.
  function automatic text_q_t random_text(int n);
    text_q_t q;
    int k;
    int conts;
    while (q.size() < n) begin
      k = $urandom_range(99);
      if (k < 45) begin
        q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end else if (k < 70) begin
        q.push_back(CHAR_SPACE);
      end else if (k < 78) begin
        q.push_back(CHAR_NL);
      end else if (k < 88) begin
        conts = $urandom_range(1, 2);
        q.push_back(conts == 1 ? 8'($urandom_range(8'hC2, 8'hDF))
                               : 8'($urandom_range(8'hE0, 8'hEF)));
        repeat (conts) q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (k < 93) begin
        q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        q.push_back(8'($urandom_range(255)));
      end
    end
    return q;
  endfunction

  function automatic setting_t setting_for(int k);
    case (k)
      0: return '{8, 1, 1, 40, 0, 255, 0};
      1: return '{255, 255, 1, 32767, 0, 255, 0};
      2: return '{0, 0, 1, 0, 0, 255, 0};
      3: return '{8, 1, 0, 5, 0, 255, 0};
      4: return '{8, 1, 2, 15, 0, 255, 0};
      5: return '{4, 1, 1, 14, 3, 1, 1};
      6: return '{4, 1, 1, 14, 1, 2, 0};
      7: return '{4, 2, 1, 20, 0, 0, 0};
      8: return '{4, 0, 3, 30, 65535, 255, 0};
      default: return '{0, 1, 255, 600, 0, 255, 0};
    endcase
  endfunction

  initial begin
    text_q_t t;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed texts on a two-glyph line.
    load_setting('{8, 1, 1, 17, 0, 255, 0});
    send_str("a bcd");
    send_str("ab    c");
    send_str("a\n   ");
    send_text('{8'hE2, 8'h82, 8'hAC, 8'hE2, 8'h82, 8'hAC, 8'h80, 8'hE2});

    // Random texts across a range of settings; two phases run without any idling.
    for (int k = 0; k < 10; k++) begin
      calm = (k == 2 || k == 3);
      load_setting(setting_for(k));
      for (int n = 0; n < 3; n++) begin
        t = random_text((k == 9 && n == 0) ? 6 : $urandom_range(1, 4));
        foreach (t[i]) begin
          // Widen the line halfway through one text.
          if (k == 9 && n == 0 && i == t.size() / 2) begin
            drain();
            write_reg(CFG_MAX_WIDTH, 1200);
            cfg_we <= 1'b0;
          end
          send_byte(t[i], i == t.size() - 1);
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gww_pkg.sv
rtl/greedy_word_wrap_unit.sv
tb/greedy_word_wrap_unit_tb.sv
